// ===== sv/rmq_pkg.sv =====
package rmq_pkg;

   // Default field width and the number of quaternion components.
   localparam int DATA_WIDTH_DEF = 16;
   localparam int NUM_LANES      = 4;

   // Which quaternion component carries the pivot.
   typedef enum logic [1:0] {
      BR_X,
      BR_Y,
      BR_Z,
      BR_W
   } rmq_branch_type;

   // Pipeline control handed to the square root and divider sections.
   typedef struct packed {
      logic advance;
      logic valid;
   } rmq_ctl_type;

endpackage

// ===== sv/rotation_matrix_to_quaternion_core.sv =====
// Rotation matrix to quaternion converter.
//
// The request channel carries the nine elements of a 3x3 rotation matrix,
// req_r00 through req_r22, each signed Q1.(DATA_WIDTH-2). The response channel
// returns the quaternion rsp_quat_x/y/z/w in the same format, saturated.
// Both channels use valid and stall: a transfer happens at a rising clock
// edge where valid is high and stall is low.
//
// The datapath is a fixed pipeline of 2*DATA_WIDTH+6 register stages: three
// front-end stages pick the branch and form the pivot and components, one
// stage per root bit runs the square root, one setup stage plus one stage
// per quotient bit runs four dividers side by side, and one output register
// saturates. A new matrix is taken every cycle unless an output stall
// holds the pipeline.
//
// When the receiver stalls while a response is waiting, the whole pipeline
// holds and req_stall goes high in the same cycle; nothing is dropped or
// repeated. Empty stages are not squeezed out. Synchronous reset clears all
// valid bits; data registers are left as they are.
module rotation_matrix_to_quaternion_core
   import rmq_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [DATA_WIDTH-1:0]  req_r00,
   input  logic signed [DATA_WIDTH-1:0]  req_r01,
   input  logic signed [DATA_WIDTH-1:0]  req_r02,
   input  logic signed [DATA_WIDTH-1:0]  req_r10,
   input  logic signed [DATA_WIDTH-1:0]  req_r11,
   input  logic signed [DATA_WIDTH-1:0]  req_r12,
   input  logic signed [DATA_WIDTH-1:0]  req_r20,
   input  logic signed [DATA_WIDTH-1:0]  req_r21,
   input  logic signed [DATA_WIDTH-1:0]  req_r22,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [DATA_WIDTH-1:0]  rsp_quat_x,
   output logic signed [DATA_WIDTH-1:0]  rsp_quat_y,
   output logic signed [DATA_WIDTH-1:0]  rsp_quat_z,
   output logic signed [DATA_WIDTH-1:0]  rsp_quat_w
);

   localparam int FRAC  = DATA_WIDTH - 2;
   localparam int SW    = DATA_WIDTH + 1;   // pairwise sums and differences
   localparam int TW    = DATA_WIDTH + 2;   // pivot and components, signed
   localparam int MW    = DATA_WIDTH + 1;   // component magnitude
   localparam int QW    = DATA_WIDTH + 1;   // quotient
   localparam int SIDEW = NUM_LANES * (MW + 1);

   localparam logic signed [TW-1:0] ONE =
      {{(TW-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};
   localparam logic signed [TW-1:0] PIVOT_FLOOR = TW'(1);
   localparam logic [DATA_WIDTH-1:0] QMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] QMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   // The pipeline moves as a whole unless the output register holds a
   // response that the receiver is stalling.
   logic        rsp_valid_ff;
   logic        advance;
   rmq_ctl_type sqrt_ctl;
   rmq_ctl_type div_ctl;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // ---------------------------------------------------------------------
   // Stage A: pairwise sums and differences, branch selection.
   // Negative r22 picks x or y by r00 > r11; otherwise z is picked when
   // r00 + r11 is negative, and w when it is not.
   // ---------------------------------------------------------------------
   logic                  valid_a_ff;
   logic signed [SW-1:0]  p_dif_a_ff, p_sum_a_ff;
   logic signed [SW-1:0]  s01_a_ff, d01_a_ff, s20_a_ff, d20_a_ff, s12_a_ff, d12_a_ff;
   logic signed [SW-1:0]  p_sum_in;
   logic signed [DATA_WIDTH-1:0] r22_a_ff;
   rmq_branch_type        sel_in, sel_a_ff;

   assign p_sum_in = SW'(req_r00) + SW'(req_r11);

   always_comb begin
      if (req_r22[DATA_WIDTH-1]) begin
         sel_in = (req_r00 > req_r11) ? BR_X : BR_Y;
      end else begin
         sel_in = p_sum_in[SW-1] ? BR_Z : BR_W;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_dif_a_ff <= SW'(req_r00) - SW'(req_r11);
         p_sum_a_ff <= p_sum_in;
         s01_a_ff   <= SW'(req_r01) + SW'(req_r10);
         d01_a_ff   <= SW'(req_r01) - SW'(req_r10);
         s20_a_ff   <= SW'(req_r20) + SW'(req_r02);
         d20_a_ff   <= SW'(req_r20) - SW'(req_r02);
         s12_a_ff   <= SW'(req_r12) + SW'(req_r21);
         d12_a_ff   <= SW'(req_r12) - SW'(req_r21);
         r22_a_ff   <= req_r22;
         sel_a_ff   <= sel_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage B: pivot t = one + (+/- diagonal pair) + (+/- r22), clamped to
   // one LSB if it is not positive, and the four components in x, y, z, w
   // order with t placed on the chosen lane.
   // ---------------------------------------------------------------------
   logic signed [TW-1:0] pa, rb, t_raw, t_val;
   logic signed [TW-1:0] comp_in [NUM_LANES];
   logic signed [TW-1:0] comp_b_ff [NUM_LANES];
   logic [DATA_WIDTH:0]  t_b_ff;
   logic                 valid_b_ff;

   always_comb begin
      case (sel_a_ff)
         BR_X: begin
            pa = TW'(p_dif_a_ff);
            rb = -TW'(r22_a_ff);
         end
         BR_Y: begin
            pa = -TW'(p_dif_a_ff);
            rb = -TW'(r22_a_ff);
         end
         BR_Z: begin
            pa = -TW'(p_sum_a_ff);
            rb = TW'(r22_a_ff);
         end
         default: begin
            pa = TW'(p_sum_a_ff);
            rb = TW'(r22_a_ff);
         end
      endcase
      t_raw = ONE + pa + rb;
      t_val = (t_raw[TW-1] || (t_raw == '0)) ? PIVOT_FLOOR : t_raw;
   end

   always_comb begin
      case (sel_a_ff)
         BR_X: begin
            comp_in[0] = t_val;
            comp_in[1] = TW'(s01_a_ff);
            comp_in[2] = TW'(s20_a_ff);
            comp_in[3] = TW'(d12_a_ff);
         end
         BR_Y: begin
            comp_in[0] = TW'(s01_a_ff);
            comp_in[1] = t_val;
            comp_in[2] = TW'(s12_a_ff);
            comp_in[3] = TW'(d20_a_ff);
         end
         BR_Z: begin
            comp_in[0] = TW'(s20_a_ff);
            comp_in[1] = TW'(s12_a_ff);
            comp_in[2] = t_val;
            comp_in[3] = TW'(d01_a_ff);
         end
         default: begin
            comp_in[0] = TW'(d12_a_ff);
            comp_in[1] = TW'(d20_a_ff);
            comp_in[2] = TW'(d01_a_ff);
            comp_in[3] = t_val;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (advance) begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            comp_b_ff[l] <= comp_in[l];
         end
         t_b_ff <= t_val[DATA_WIDTH:0];
      end
   end

   // ---------------------------------------------------------------------
   // Stage C: sign and magnitude of each component, radicand t * 2^F.
   // ---------------------------------------------------------------------
   logic                          valid_c_ff;
   logic [NUM_LANES-1:0][MW-1:0]  mag_c_ff;
   logic [NUM_LANES-1:0]          neg_c_ff;
   logic [2*DATA_WIDTH-1:0]       rad_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
      end else if (advance) begin
         valid_c_ff <= valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            neg_c_ff[l] <= comp_b_ff[l][TW-1];
            mag_c_ff[l] <= comp_b_ff[l][TW-1] ? MW'(-comp_b_ff[l]) : MW'(comp_b_ff[l]);
         end
         rad_c_ff <= {1'b0, t_b_ff, {FRAC{1'b0}}};
      end
   end

   // ---------------------------------------------------------------------
   // Square root of the radicand; component signs and magnitudes ride along.
   // ---------------------------------------------------------------------
   logic                          sqrt_valid;
   logic [DATA_WIDTH-1:0]         sqrt_root;
   logic [SIDEW-1:0]              sqrt_side;
   logic [NUM_LANES-1:0][MW-1:0]  sqrt_mag;
   logic [NUM_LANES-1:0]          sqrt_neg;

   assign sqrt_ctl.advance = advance;
   assign sqrt_ctl.valid   = valid_c_ff;

   rmq_isqrt #(
      .DATA_WIDTH (DATA_WIDTH),
      .SIDE_WIDTH (SIDEW)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .ctl       (sqrt_ctl),
      .rad       (rad_c_ff),
      .side      ({neg_c_ff, mag_c_ff}),
      .out_valid (sqrt_valid),
      .out_root  (sqrt_root),
      .out_side  (sqrt_side)
   );

   assign {sqrt_neg, sqrt_mag} = sqrt_side;

   // ---------------------------------------------------------------------
   // Four dividers: round(mag * 2^F / (2 * root)), half away from zero.
   // ---------------------------------------------------------------------
   logic                          div_valid;
   logic [NUM_LANES-1:0][QW-1:0]  div_quot;
   logic [NUM_LANES-1:0]          div_neg;

   assign div_ctl.advance = advance;
   assign div_ctl.valid   = sqrt_valid;

   rmq_div #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .in_mag    (sqrt_mag),
      .in_neg    (sqrt_neg),
      .in_root   (sqrt_root),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_neg   (div_neg)
   );

   // ---------------------------------------------------------------------
   // Output register: restore the sign and saturate to the field range.
   // ---------------------------------------------------------------------
   logic [DATA_WIDTH-1:0] quat_in [NUM_LANES];
   logic [DATA_WIDTH-1:0] quat_ff [NUM_LANES];

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         if (!div_neg[l]) begin
            quat_in[l] = (div_quot[l][QW-1:DATA_WIDTH-1] != '0) ? QMAX
                                                              : div_quot[l][DATA_WIDTH-1:0];
         end else if (div_quot[l][QW-1] ||
                      (div_quot[l][DATA_WIDTH-1] && (div_quot[l][DATA_WIDTH-2:0] != '0))) begin
            quat_in[l] = QMIN;
         end else begin
            quat_in[l] = DATA_WIDTH'(~div_quot[l][DATA_WIDTH-1:0] + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            quat_ff[l] <= quat_in[l];
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_quat_x = quat_ff[0];
   assign rsp_quat_y = quat_ff[1];
   assign rsp_quat_z = quat_ff[2];
   assign rsp_quat_w = quat_ff[3];

   // Every branch keeps the pivot at one or above; the divider width and the
   // quotient bound depend on it.
   a_pivot_min: assert property (@(posedge clock) disable iff (reset)
      valid_b_ff |-> (t_b_ff[DATA_WIDTH:FRAC] != '0))
      else $error("pivot below one");

   // A stalled response must freeze the front end as well.
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable({valid_a_ff, valid_b_ff, valid_c_ff}))
      else $error("front-end stages moved during an output stall");

endmodule

// ===== sv/rmq_isqrt.sv =====
module rmq_isqrt
   import rmq_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int SIDE_WIDTH = NUM_LANES * (DATA_WIDTH + 2)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rmq_ctl_type               ctl,
   input  logic [2*DATA_WIDTH-1:0]   rad,
   input  logic [SIDE_WIDTH-1:0]     side,
   output logic                      out_valid,
   output logic [DATA_WIDTH-1:0]     out_root,
   output logic [SIDE_WIDTH-1:0]     out_side
);

   localparam int RADW = 2 * DATA_WIDTH;
   localparam int REMW = DATA_WIDTH + 2;
   localparam int LAST = DATA_WIDTH - 1;

   // One result bit per stage, two radicand bits consumed per stage.
   logic                  valid_ff [DATA_WIDTH];
   logic [RADW-1:0]       rad_ff   [DATA_WIDTH];
   logic [DATA_WIDTH-1:0] root_ff  [DATA_WIDTH];
   logic [REMW-1:0]       rem_ff   [DATA_WIDTH];
   logic [SIDE_WIDTH-1:0] side_ff  [DATA_WIDTH];

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_stage
      logic                  valid_src;
      logic [RADW-1:0]       rad_src;
      logic [DATA_WIDTH-1:0] root_src;
      logic [REMW-1:0]       rem_src;
      logic [SIDE_WIDTH-1:0] side_src;
      logic [REMW-1:0]       rem_sh;
      logic [REMW-1:0]       trial;
      logic [REMW-1:0]       rem_in;
      logic [DATA_WIDTH-1:0] root_in;

      if (i == 0) begin : g_first
         assign valid_src = ctl.valid;
         assign rad_src   = rad;
         assign root_src  = '0;
         assign rem_src   = '0;
         assign side_src  = side;
      end else begin : g_next
         assign valid_src = valid_ff[i-1];
         assign rad_src   = rad_ff[i-1];
         assign root_src  = root_ff[i-1];
         assign rem_src   = rem_ff[i-1];
         assign side_src  = side_ff[i-1];
      end

      always_comb begin
         rem_sh = {rem_src[DATA_WIDTH-1:0], rad_src[RADW-1-2*i -: 2]};
         trial  = {root_src, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_src[DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_src[DATA_WIDTH-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (ctl.advance) begin
            valid_ff[i] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.advance) begin
            rad_ff[i]  <= rad_src;
            root_ff[i] <= root_in;
            rem_ff[i]  <= rem_in;
            side_ff[i] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[LAST];
   assign out_root  = root_ff[LAST];
   assign out_side  = side_ff[LAST];

   // The root and remainder must reconstruct the radicand exactly.
   a_root_exact: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> ((RADW+1)'(out_root) * (RADW+1)'(out_root) + (RADW+1)'(rem_ff[LAST])
                     == (RADW+1)'(rad_ff[LAST])))
      else $error("square root does not reconstruct the radicand");

   // A remainder above twice the root means the root was floored too far.
   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (rem_ff[LAST] <= REMW'({out_root, 1'b0})))
      else $error("square root remainder out of range");

endmodule

// ===== sv/rmq_div.sv =====
module rmq_div
   import rmq_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rmq_ctl_type                          ctl,
   input  logic [NUM_LANES-1:0][DATA_WIDTH:0]   in_mag,
   input  logic [NUM_LANES-1:0]                 in_neg,
   input  logic [DATA_WIDTH-1:0]                in_root,
   output logic                                 out_valid,
   output logic [NUM_LANES-1:0][DATA_WIDTH:0]   out_quot,
   output logic [NUM_LANES-1:0]                 out_neg
);

   localparam int FRAC = DATA_WIDTH - 2;
   localparam int NW   = 2 * DATA_WIDTH;
   localparam int DW   = DATA_WIDTH + 1;
   localparam int QW   = DATA_WIDTH + 1;
   localparam int CW   = NW + 2;
   localparam int LAST = QW - 1;

   // Setup stage: numerator mag * 2^F + root (rounds half away from zero),
   // divisor twice the root.
   logic                            pvalid_ff;
   logic [NUM_LANES-1:0][NW-1:0]    pnum_ff;
   logic [NUM_LANES-1:0]            pneg_ff;
   logic [DW-1:0]                   pden_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
      end else if (ctl.advance) begin
         pvalid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            pnum_ff[l] <= NW'({in_mag[l], {FRAC{1'b0}}}) + NW'(in_root);
         end
         pneg_ff <= in_neg;
         pden_ff <= {in_root, 1'b0};
      end
   end

   // Restoring division, one quotient bit per stage. The quotient never
   // reaches 2^QW, so the top numerator bits start below the divisor.
   logic                          valid_ff [QW];
   logic [NUM_LANES-1:0][NW-1:0]  num_ff   [QW];
   logic [NUM_LANES-1:0][DW-1:0]  rem_ff   [QW];
   logic [NUM_LANES-1:0][QW-1:0]  quot_ff  [QW];
   logic [NUM_LANES-1:0]          neg_ff   [QW];
   logic [DW-1:0]                 den_ff   [QW];

   for (genvar j = 0; j < QW; j++) begin : g_step
      logic                          valid_src;
      logic [NUM_LANES-1:0][NW-1:0]  num_src;
      logic [NUM_LANES-1:0][DW-1:0]  rem_src;
      logic [NUM_LANES-1:0][QW-1:0]  quot_src;
      logic [NUM_LANES-1:0]          neg_src;
      logic [DW-1:0]                 den_src;
      logic [NUM_LANES-1:0][DW:0]    rem_sh;
      logic [NUM_LANES-1:0][DW-1:0]  rem_in;
      logic [NUM_LANES-1:0][QW-1:0]  quot_in;

      if (j == 0) begin : g_first
         assign valid_src = pvalid_ff;
         assign num_src   = pnum_ff;
         assign neg_src   = pneg_ff;
         assign den_src   = pden_ff;
         assign quot_src  = '0;
         always_comb begin
            for (int l = 0; l < NUM_LANES; l++) begin
               rem_src[l] = DW'(pnum_ff[l][NW-1:QW]);
            end
         end
      end else begin : g_next
         assign valid_src = valid_ff[j-1];
         assign num_src   = num_ff[j-1];
         assign neg_src   = neg_ff[j-1];
         assign den_src   = den_ff[j-1];
         assign quot_src  = quot_ff[j-1];
         assign rem_src   = rem_ff[j-1];
      end

      always_comb begin
         for (int l = 0; l < NUM_LANES; l++) begin
            rem_sh[l] = {rem_src[l], num_src[l][QW-1-j]};
            if (rem_sh[l] >= {1'b0, den_src}) begin
               rem_in[l]  = DW'(rem_sh[l] - {1'b0, den_src});
               quot_in[l] = {quot_src[l][QW-2:0], 1'b1};
            end else begin
               rem_in[l]  = DW'(rem_sh[l]);
               quot_in[l] = {quot_src[l][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (ctl.advance) begin
            valid_ff[j] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.advance) begin
            num_ff[j]  <= num_src;
            rem_ff[j]  <= rem_in;
            quot_ff[j] <= quot_in;
            neg_ff[j]  <= neg_src;
            den_ff[j]  <= den_src;
         end
      end
   end

   assign out_valid = valid_ff[LAST];
   assign out_quot  = quot_ff[LAST];
   assign out_neg   = neg_ff[LAST];

   logic [NUM_LANES-1:0] div_ok;

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         div_ok[l] = ((CW'(quot_ff[LAST][l]) * CW'(den_ff[LAST]) + CW'(rem_ff[LAST][l])
                       == CW'(num_ff[LAST][l])) && (rem_ff[LAST][l] < den_ff[LAST]));
      end
   end

   // Every lane must leave an exact quotient and a remainder below the divisor.
   a_div_exact: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (&div_ok))
      else $error("divider lane does not satisfy quotient identity");

   // The quotient width rests on the divisor being at least 2^(F+1).
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      pvalid_ff |-> (pden_ff[DW-1:FRAC+1] != '0))
      else $error("divisor below the range that bounds the quotient");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

// Testbench for the rotation matrix to quaternion core.
module tb_top
   import rmq_pkg::*;
();

   // Field format: DW-bit two's complement with FRAC fraction bits, so that
   // the raw value ONE stands for 1.0.
   localparam int DW        = DATA_WIDTH_DEF;
   localparam int FRAC      = DW - 2;
   localparam longint ONE   = longint'(1) << FRAC;
   localparam real ONE_R    = real'(ONE);
   localparam longint unsigned POS_LIMIT = (64'd1 << (DW - 1)) - 1;
   localparam longint unsigned NEG_LIMIT = 64'd1 << (DW - 1);

   // Depth of the core pipeline in register stages, used to let it drain.
   localparam int LATENCY      = 2 * DW + 6;
   localparam int RANDOM_ITEMS = 1200;
   localparam int STUCK_LIMIT  = 2000;
   localparam int REPORT_MAX   = 10;

   typedef logic signed [DW-1:0] fix_type;

   typedef struct packed {
      fix_type r00, r01, r02, r10, r11, r12, r20, r21, r22;
   } matrix_type;

   typedef struct packed {
      fix_type x, y, z, w;
   } quat_type;

   // One line of the directed stimulus. Where known is set, q holds the
   // quaternion as worked out by hand; otherwise the predictor supplies it.
   typedef struct packed {
      matrix_type m;
      logic       known;
      quat_type   q;
   } directed_row_type;

   localparam int NUM_DIRECTED = 17;

   // Diagonal entries pick the branch, so most rows sit on or next to a
   // branch boundary. The hand-typed results come from pivots that are
   // exact powers of two.
   directed_row_type directed_rows [NUM_DIRECTED] = '{
      // Identity: no rotation, w carries the pivot.
      '{'{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}, 1'b1, '{0, 0, 0, 16384}},
      // All zero: pivot is exactly one, so w comes out as one half.
      '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 8192}},
      // Half turns about x, y and z, one per pivot branch.
      '{'{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}, 1'b1, '{16384, 0, 0, 0}},
      '{'{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}, 1'b1, '{0, 16384, 0, 0}},
      '{'{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}, 1'b1, '{0, 0, 16384, 0}},
      // Largest positive x with the smallest pivot: clips to the top code.
      '{'{0, 0, 0, 0, 0, 32767, 0, -32768, 0}, 1'b1, '{32767, 0, 0, 8192}},
      // Mirror of the above: lands exactly on the most negative code.
      '{'{0, 0, 0, 0, 0, -32768, 0, 32767, 0}, 1'b1, '{-32768, 0, 0, 8192}},
      // Every element at one extreme or the other.
      '{'{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
        1'b0, '{0, 0, 0, 0}},
      '{'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
        1'b0, '{0, 0, 0, 0}},
      // r22 negative with r00 equal to r11: the tie goes to the y branch.
      '{'{5000, 1200, -700, 900, 5000, 333, -4000, 250, -1}, 1'b0, '{0, 0, 0, 0}},
      // r22 zero with r00 equal to -r11: the tie goes to the w branch.
      '{'{8000, -300, 1500, 2100, -8000, -999, 77, 4321, 0}, 1'b0, '{0, 0, 0, 0}},
      // One LSB across the same boundary: the z branch.
      '{'{-8001, -300, 1500, 2100, 8000, -999, 77, 4321, 0}, 1'b0, '{0, 0, 0, 0}},
      // r22 at minus one LSB and r00 one above r11: the x branch.
      '{'{5001, 4000, -3000, -2000, 5000, 1000, 600, -12000, -1}, 1'b0,
        '{0, 0, 0, 0}},
      // Quarter turn about z.
      '{'{0, -16384, 0, 16384, 0, 0, 0, 0, 16384}, 1'b0, '{0, 0, 0, 0}},
      // Large off-diagonal sums in the y branch, with r22 at its most negative.
      '{'{0, 32767, -32768, 32767, 0, -32768, -32768, -32768, -32768}, 1'b0,
        '{0, 0, 0, 0}},
      // Alternating bit patterns.
      '{'{21845, -21846, 21845, -21846, 21845, -21846, 21845, -21846, 21845},
        1'b0, '{0, 0, 0, 0}},
      '{'{-21846, 21845, -21846, 21845, -21846, 21845, -21846, 21845, -21846},
        1'b0, '{0, 0, 0, 0}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   fix_type req_r00 = '0, req_r01 = '0, req_r02 = '0;
   fix_type req_r10 = '0, req_r11 = '0, req_r12 = '0;
   fix_type req_r20 = '0, req_r21 = '0, req_r22 = '0;

   logic rsp_valid;
   logic rsp_stall = 1'b0;
   fix_type rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;

   // Quaternions still owed by the core, oldest first.
   quat_type owed_quats [$];

   int mismatches    = 0;
   int matrices_sent = 0;
   int quats_checked = 0;
   int branch_hits [4] = '{0, 0, 0, 0};
   int stuck_cycles  = 0;

   // While calm is set neither side idles, so the pipeline runs back to back.
   bit calm = 1'b0;

   rotation_matrix_to_quaternion_core #(
      .DATA_WIDTH (DW)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_r00    (req_r00),
      .req_r01    (req_r01),
      .req_r02    (req_r02),
      .req_r10    (req_r10),
      .req_r11    (req_r11),
      .req_r12    (req_r12),
      .req_r20    (req_r20),
      .req_r21    (req_r21),
      .req_r22    (req_r22),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_quat_x (rsp_quat_x),
      .rsp_quat_y (rsp_quat_y),
      .rsp_quat_z (rsp_quat_z),
      .rsp_quat_w (rsp_quat_w)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Quaternion predictor
   // ------------------------------------------------------------------

   // Integer square root, floor, one result bit per pass.
   function automatic longint unsigned floor_sqrt(input longint unsigned n);
      longint unsigned root;
      longint unsigned place;
      root  = 0;
      place = 64'd1 << 62;
      while (place > n)
         place >>= 2;
      while (place != 0) begin
         if (n >= root + place) begin
            n    -= root + place;
            root  = (root >> 1) + place;
         end else begin
            root >>= 1;
         end
         place >>= 2;
      end
      return root;
   endfunction

   // c / (2 * root) in Q1.FRAC, rounded half away from zero, then clipped to
   // the output range.
   function automatic fix_type scale_component(input longint c,
                                               input longint unsigned root);
      longint unsigned mag;
      longint unsigned quo;
      mag = (c < 0) ? longint'(-c) : c;
      quo = ((mag << FRAC) + root) / (2 * root);
      if (c < 0) begin
         if (quo > NEG_LIMIT)
            quo = NEG_LIMIT;
         return fix_type'(-longint'(quo));
      end
      if (quo > POS_LIMIT)
         quo = POS_LIMIT;
      return fix_type'(quo);
   endfunction

   // The branch follows the sign of r22 and the order of r00 against r11
   // (or -r11). The pivot t is four times the square of the component on the
   // chosen branch, and the other three come from sums and differences of
   // the off-diagonal pairs.
   function automatic quat_type predict_quat(input matrix_type m,
                                             output rmq_branch_type br);
      longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
      longint t;
      longint comp [4];
      longint unsigned root;
      quat_type q;
      a00 = m.r00; a01 = m.r01; a02 = m.r02;
      a10 = m.r10; a11 = m.r11; a12 = m.r12;
      a20 = m.r20; a21 = m.r21; a22 = m.r22;
      if (a22 < 0) begin
         if (a00 > a11) begin
            t  = ONE + a00 - a11 - a22;
            br = BR_X;
         end else begin
            t  = ONE - a00 + a11 - a22;
            br = BR_Y;
         end
      end else begin
         if (a00 < -a11) begin
            t  = ONE - a00 - a11 + a22;
            br = BR_Z;
         end else begin
            t  = ONE + a00 + a11 + a22;
            br = BR_W;
         end
      end
      // Every branch keeps the pivot at one or above, so this clamp to one
      // LSB is a guard that no input can reach.
      if (t <= 0)
         t = 1;
      case (br)
         BR_X: comp = '{t, a01 + a10, a20 + a02, a12 - a21};
         BR_Y: comp = '{a01 + a10, t, a12 + a21, a20 - a02};
         BR_Z: comp = '{a20 + a02, a12 + a21, t, a01 - a10};
         default: comp = '{a12 - a21, a20 - a02, a01 - a10, t};
      endcase
      root = floor_sqrt(longint'(t) << FRAC);
      if (root == 0)
         root = 1;
      q.x = scale_component(comp[0], root);
      q.y = scale_component(comp[1], root);
      q.z = scale_component(comp[2], root);
      q.w = scale_component(comp[3], root);
      return q;
   endfunction

   // ------------------------------------------------------------------
   // Random matrices
   // ------------------------------------------------------------------

   function automatic fix_type to_fix(input real v);
      longint k;
      k = longint'(v * ONE_R);
      if (k > longint'(POS_LIMIT))
         k = longint'(POS_LIMIT);
      if (k < -longint'(NEG_LIMIT))
         k = -longint'(NEG_LIMIT);
      return fix_type'(k);
   endfunction

   function automatic fix_type corner_value();
      case ($urandom_range(7))
         0: return fix_type'(-32768);
         1: return fix_type'(-16384);
         2: return fix_type'(-1);
         3: return fix_type'(0);
         4: return fix_type'(1);
         5: return fix_type'(16384);
         6: return fix_type'(32767);
         default: return fix_type'($urandom);
      endcase
   endfunction

   // Most matrices are true rotations built from a random unit quaternion,
   // some with a few LSBs of jitter. The rest are raw bit patterns and
   // mixtures of extreme values, which the core takes just the same.
   function automatic matrix_type random_matrix();
      real qx, qy, qz, qw, n;
      logic [9*DW-1:0] flat;
      matrix_type m;
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         qx = real'(int'($urandom_range(20000)) - 10000);
         qy = real'(int'($urandom_range(20000)) - 10000);
         qz = real'(int'($urandom_range(20000)) - 10000);
         qw = real'(int'($urandom_range(20000)) - 10000);
         n  = $sqrt(qx*qx + qy*qy + qz*qz + qw*qw);
         if (n < 1.0) begin
            qx = 0.0; qy = 0.0; qz = 0.0; qw = 1.0; n = 1.0;
         end
         qx /= n; qy /= n; qz /= n; qw /= n;
         m.r00 = to_fix(1.0 - 2.0*(qy*qy + qz*qz));
         m.r01 = to_fix(2.0*(qx*qy - qz*qw));
         m.r02 = to_fix(2.0*(qx*qz + qy*qw));
         m.r10 = to_fix(2.0*(qx*qy + qz*qw));
         m.r11 = to_fix(1.0 - 2.0*(qx*qx + qz*qz));
         m.r12 = to_fix(2.0*(qy*qz - qx*qw));
         m.r20 = to_fix(2.0*(qx*qz - qy*qw));
         m.r21 = to_fix(2.0*(qy*qz + qx*qw));
         m.r22 = to_fix(1.0 - 2.0*(qx*qx + qy*qy));
         if ($urandom_range(1) == 1) begin
            flat = m;
            for (int k = 0; k < 9; k++)
               flat[k*DW +: DW] = fix_type'(flat[k*DW +: DW])
                                  + fix_type'(int'($urandom_range(8)) - 4);
            m = flat;
         end
      end else if (pick < 80) begin
         for (int k = 0; k < 9; k++)
            flat[k*DW +: DW] = fix_type'($urandom);
         m = flat;
      end else begin
         for (int k = 0; k < 9; k++)
            flat[k*DW +: DW] = corner_value();
         m = flat;
      end
      return m;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offers one matrix and returns at the edge where its transfer happens.
   // Idle cycles are chosen before valid rises, so valid never looks at
   // stall, and the payload holds still while the core stalls.
   task automatic send_matrix(input matrix_type m, input logic known,
                              input quat_type typed_q);
      quat_type q;
      rmq_branch_type br;
      while (!calm && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_r00   <= m.r00;
      req_r01   <= m.r01;
      req_r02   <= m.r02;
      req_r10   <= m.r10;
      req_r11   <= m.r11;
      req_r12   <= m.r12;
      req_r20   <= m.r20;
      req_r21   <= m.r21;
      req_r22   <= m.r22;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      q = predict_quat(m, br);
      branch_hits[br]++;
      owed_quats.push_back(known ? typed_q : q);
      matrices_sent++;
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Values sampled here are the ones from before the edge, since the core
   // registers and the bench's request, stall and reset signals all change
   // through nonblocking assignments.
   always @(posedge clock) begin
      quat_type got;
      quat_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w};
            quats_checked++;
            if (owed_quats.size() == 0) begin
               note_mismatch($sformatf("quaternion x=%0d y=%0d z=%0d w=%0d with none owed",
                                       got.x, got.y, got.z, got.w));
            end else begin
               want = owed_quats.pop_front();
               if (got.x !== want.x || got.y !== want.y ||
                   got.z !== want.z || got.w !== want.w)
                  note_mismatch($sformatf({"result %0d expected x=%0d y=%0d z=%0d w=%0d,",
                                           " got x=%0d y=%0d z=%0d w=%0d"},
                                          quats_checked, want.x, want.y, want.z,
                                          want.w, got.x, got.y, got.z, got.w));
            end
         end
         rsp_stall <= !calm && ($urandom_range(99) < 28);
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: counts cycles without a transfer on either channel.
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
   end

   initial begin
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("[%0t] no transfer for %0d cycles, %0d quaternions still owed",
               $time, STUCK_LIMIT, owed_quats.size());
      $display("TEST FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_matrix(directed_rows[i].m, directed_rows[i].known, directed_rows[i].q);

      // A stretch in the middle runs with no idling on either side, so the
      // pipeline is filled and drained at full rate.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm = (i >= 400 && i < 700);
         send_matrix(random_matrix(), 1'b0, '0);
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (owed_quats.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      // Anything still owed at this point never came back.
      if (owed_quats.size() != 0)
         note_mismatch($sformatf("%0d quaternions never returned", owed_quats.size()));

      $display("Sent %0d matrices (%0d directed), checked %0d quaternions, %0d mismatches.",
               matrices_sent, NUM_DIRECTED, quats_checked, mismatches);
      $display("Pivot branch hits: x %0d, y %0d, z %0d, w %0d.",
               branch_hits[BR_X], branch_hits[BR_Y], branch_hits[BR_Z], branch_hits[BR_W]);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/rmq_pkg.sv
sv/rmq_isqrt.sv
sv/rmq_div.sv
sv/rotation_matrix_to_quaternion_core.sv
bench/tb_top.sv
